// ----- rtl/rkf_pkg.sv -----
// rkf_pkg: shared types and constants of the request keyword filter.
// Item structs, operation codes, register indexes and action codes.
`timescale 1ns / 1ps
`default_nettype none
package rkf_pkg;

  localparam int KEYWORDS_DEF        = 16;
  localparam int MAX_KEYWORD_LEN_DEF = 32;

  localparam int LEN_W   = 6;
  localparam int POS_W   = 5;
  localparam int KIDX_W  = 4;
  localparam int BYTE_W  = 8;

  localparam logic [1:0] OP_LOAD_BYTE = 2'd0;
  localparam logic [1:0] OP_LOAD_ATTR = 2'd1;
  localparam logic [1:0] OP_SCAN      = 2'd2;

  localparam logic [1:0] CFG_KEYWORD_COUNT = 2'd0;
  localparam logic [1:0] CFG_REMIND_MODE   = 2'd1;
  localparam logic [1:0] CFG_POLICY_ID     = 2'd2;

  localparam logic [1:0] ACT_NONE     = 2'd0;
  localparam logic [1:0] ACT_REDIRECT = 2'd1;
  localparam logic [1:0] ACT_TCP_RST  = 2'd2;

  localparam logic [7:0] SKIP_PLUS = 8'h2B;
  localparam logic [7:0] SKIP_STAR = 8'h2A;

  typedef struct packed {
    logic [1:0]        op;
    logic [KIDX_W-1:0] keyword_index;
    logic              variant;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] value;
    logic [LEN_W-1:0]  length;
    logic              pass_on_match;
    logic              log_on_match;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic              matched;
    logic [KIDX_W-1:0] match_index;
    logic              verdict_pass;
    logic [1:0]        action;
    logic              log_request;
    logic [7:0]        policy;
  } out_item_t;

  function automatic logic is_skip(input logic [7:0] b);
    return (b == SKIP_PLUS) || (b == SKIP_STAR);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rkf_cell.sv -----
// rkf_cell: one byte of the recent-byte window.
// Shifts toward the older end; depends on nothing but its neighbor.
`timescale 1ns / 1ps
`default_nettype none
module rkf_cell (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       clear_i,
  input  wire logic       shift_i,
  input  wire logic [7:0] din_i,
  output logic      [7:0] q_o,
  output logic      [7:0] base_o
);
  logic [7:0] byte_r, byte_nxt;

  assign base_o   = clear_i ? 8'd0 : byte_r;
  assign byte_nxt = shift_i ? din_i : base_o;
  assign q_o      = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'd0;
    end else begin
      byte_r <= byte_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/rkf_match.sv -----
// rkf_match: one pattern (keyword in one encoding) and its window compare.
// Uses rkf_pkg; the window comes from the rkf_cell chain.
`timescale 1ns / 1ps
`default_nettype none
module rkf_match import rkf_pkg::*; #(
  parameter int MAX_KEYWORD_LEN = MAX_KEYWORD_LEN_DEF,
  localparam int PW = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1,
  localparam int FW = $clog2(MAX_KEYWORD_LEN + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_byte_i,
  input  wire logic [PW-1:0]     pos_i,
  input  wire logic [7:0]        val_i,
  input  wire logic              wr_len_i,
  input  wire logic [LEN_W-1:0]  len_i,
  input  wire logic [7:0]        win_i [MAX_KEYWORD_LEN],
  input  wire logic [FW-1:0]     fill_i,
  output logic                   hit_o
);
  logic [7:0]       pb_r [MAX_KEYWORD_LEN];
  logic [LEN_W-1:0] len_r;

  always_ff @(posedge clk) begin
    if (wr_byte_i) begin
      pb_r[pos_i] <= val_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (wr_len_i) begin
      len_r <= len_i;
    end
  end

  // Pattern is right-aligned to the newest window byte.
  always_comb begin
    logic ok;
    logic [LEN_W+PW:0] off;
    ok = (len_r != '0) && (int'(len_r) <= MAX_KEYWORD_LEN) &&
         (int'(len_r) <= int'(fill_i));
    for (int j = 0; j < MAX_KEYWORD_LEN; j++) begin
      if (j < int'(len_r) && is_skip(pb_r[j])) ok = 1'b0;
    end
    for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
      off = (LEN_W+PW+1)'(i) + (LEN_W+PW+1)'(len_r) - (LEN_W+PW+1)'(MAX_KEYWORD_LEN);
      if (i + int'(len_r) >= MAX_KEYWORD_LEN && i + int'(len_r) < 2 * MAX_KEYWORD_LEN) begin
        if (win_i[i] != pb_r[off[PW-1:0]]) ok = 1'b0;
      end
    end
    hit_o = ok;
  end
endmodule
`default_nettype wire

// ----- rtl/request_keyword_filter.sv -----
// request_keyword_filter: top level, keyword table load, byte window chain,
// per-pattern matchers and verdict. Uses rkf_pkg, rkf_cell, rkf_match.
//
// Usage:
//  - in_valid/in_ready/in_data carry items: keyword byte loads, keyword
//    attribute loads, and request bytes. '+' and '*' request bytes never
//    enter the window. One result item per request, on the last byte.
//  - out_valid/out_ready/out_data carry the verdict item.
//  - cfg_valid/cfg_ready/cfg_index/cfg_data write keyword_count,
//    remind_mode, policy_id; cfg_ready is always high.
//  - Throughput: one item per cycle while in_ready is high. A byte enters
//    the window chain at its accept edge; all patterns compare against the
//    window in the next cycle, where the hit flags update.
//  - Result: the last byte sets pend_last_r; the verdict is then registered
//    into the output register once that register is empty or being taken.
//  - Stall: while a verdict is pending and the output register is full and
//    not taken, in_ready drops; otherwise items keep flowing.
//  - Reset (rst_n low, sync): window, fill, hit flags, lengths, flags and
//    config are cleared; keyword bytes are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module request_keyword_filter import rkf_pkg::*; #(
  parameter int KEYWORDS        = KEYWORDS_DEF,
  parameter int MAX_KEYWORD_LEN = MAX_KEYWORD_LEN_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  localparam int NPAT = 2 * KEYWORDS;
  localparam int PW   = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;
  localparam int FW   = $clog2(MAX_KEYWORD_LEN + 1);

  // configuration
  logic [4:0] kcount_r;
  logic       remind_r;
  logic [7:0] policy_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kcount_r <= '0;
      remind_r <= 1'b0;
      policy_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEYWORD_COUNT: kcount_r <= cfg_data[4:0];
        CFG_REMIND_MODE:   remind_r <= cfg_data[0];
        CFG_POLICY_ID:     policy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake and pending compare stage
  logic pend_cmp_r, pend_last_r, adv, acc, scan_in;
  logic out_valid_r;
  out_item_t out_data_r;

  assign adv      = !pend_last_r || !out_valid_r || out_ready;
  assign in_ready = adv;
  assign acc      = in_valid && in_ready;
  assign scan_in  = acc && (in_data.op == OP_SCAN) && !is_skip(in_data.value);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cmp_r  <= 1'b0;
      pend_last_r <= 1'b0;
    end else if (adv) begin
      pend_cmp_r  <= scan_in;
      pend_last_r <= acc && (in_data.op == OP_SCAN) && in_data.last;
    end
  end

  // window chain, index MAX_KEYWORD_LEN-1 is newest
  logic [7:0] win_q    [MAX_KEYWORD_LEN];
  logic [7:0] win_base [MAX_KEYWORD_LEN];
  logic       clr;

  assign clr = adv && pend_last_r;

  for (genvar i = 0; i < MAX_KEYWORD_LEN; i++) begin : g_cell
    logic [7:0] din;
    if (i == MAX_KEYWORD_LEN - 1) begin : g_new
      assign din = in_data.value;
    end else begin : g_old
      assign din = win_base[i+1];
    end
    rkf_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .clear_i(clr),
      .shift_i(scan_in),
      .din_i  (din),
      .q_o    (win_q[i]),
      .base_o (win_base[i])
    );
  end

  logic [FW-1:0] fill_r, fill_base;
  assign fill_base = clr ? '0 : fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (scan_in && int'(fill_base) < MAX_KEYWORD_LEN) begin
      fill_r <= fill_base + FW'(1);
    end else begin
      fill_r <= fill_base;
    end
  end

  // pattern matchers; pattern p = 2 * keyword + variant
  logic         ld_byte, ld_attr;
  logic [PW-1:0] pos_idx;
  logic [NPAT-1:0] cur_hit;

  assign ld_byte = acc && (in_data.op == OP_LOAD_BYTE) &&
                   (int'(in_data.keyword_index) < KEYWORDS) &&
                   (int'(in_data.position) < MAX_KEYWORD_LEN);
  assign ld_attr = acc && (in_data.op == OP_LOAD_ATTR) &&
                   (int'(in_data.keyword_index) < KEYWORDS);
  assign pos_idx = PW'(in_data.position);

  for (genvar p = 0; p < NPAT; p++) begin : g_pat
    logic sel;
    assign sel = (int'(in_data.keyword_index) == p / 2) &&
                 (in_data.variant == 1'(p % 2));
    rkf_match #(.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)) u_match (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_byte_i(ld_byte && sel),
      .pos_i    (pos_idx),
      .val_i    (in_data.value),
      .wr_len_i (ld_attr && sel),
      .len_i    (in_data.length),
      .win_i    (win_q),
      .fill_i   (fill_r),
      .hit_o    (cur_hit[p])
    );
  end

  // keyword flags
  logic [KEYWORDS-1:0] pass_r, log_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= '0;
      log_r  <= '0;
    end else if (ld_attr) begin
      for (int k = 0; k < KEYWORDS; k++) begin
        if (int'(in_data.keyword_index) == k) begin
          pass_r[k] <= in_data.pass_on_match;
          log_r[k]  <= in_data.log_on_match;
        end
      end
    end
  end

  // hit flags, sticky within a request
  logic [NPAT-1:0] hits_r, hits_all;
  assign hits_all = hits_r | (pend_cmp_r ? cur_hit : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r <= '0;
    end else if (adv) begin
      hits_r <= pend_last_r ? '0 : hits_all;
    end
  end

  // verdict: lowest matching keyword below keyword_count
  out_item_t res;
  always_comb begin
    logic found;
    logic pf, lf;
    found = 1'b0;
    pf    = 1'b0;
    lf    = 1'b0;
    res   = '0;
    for (int k = 0; k < KEYWORDS; k++) begin
      if (!found && k < int'(kcount_r) && (hits_all[2*k] || hits_all[2*k+1])) begin
        found           = 1'b1;
        res.match_index = KIDX_W'(k);
        pf              = pass_r[k];
        lf              = log_r[k];
      end
    end
    res.matched      = found;
    res.verdict_pass = !found || pf;
    res.action       = (found && !pf) ? (remind_r ? ACT_REDIRECT : ACT_TCP_RST) : ACT_NONE;
    res.log_request  = found && lf;
    res.policy       = policy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (clr) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule
`default_nettype wire

// ----- sim/tb_request_keyword_filter.sv -----
// tb_request_keyword_filter: self-checking testbench of request_keyword_filter.
// Loads keyword tables, streams requests and checks each verdict item against
// a local predictor. Depends on rtl/rkf_pkg.sv and rtl/request_keyword_filter.sv.
`timescale 1ns / 1ps
module tb_request_keyword_filter;
  import rkf_pkg::*;

  localparam int NKW  = KEYWORDS_DEF;
  localparam int KLEN = MAX_KEYWORD_LEN_DEF;
  localparam int NPAT = NKW * 2;
  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  request_keyword_filter i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: keyword table, byte window, hit flags and registers.
  // Pattern p = keyword * 2 + variant.
  // ---------------------------------------------------------------------------
  logic [7:0]       kw_bytes [NPAT][KLEN];
  bit               kw_written [NPAT][KLEN];  // guards against reading unloaded bytes
  logic [LEN_W-1:0] kw_len [NPAT];
  logic             kw_pass [NKW];
  logic             kw_log [NKW];
  logic [7:0]       window [KLEN];           // newest byte at KLEN-1
  int               fill;
  logic             hits [NPAT];
  logic [4:0]       reg_count;
  logic             reg_remind;
  logic [7:0]       reg_policy;

  out_item_t verdict_q[$];   // verdicts still owed by the block
  int        errors;
  int        items_sent;
  int        snd_idle;       // percent of cycles the sender holds off
  int        rcv_idle;       // percent of cycles the receiver stalls

  function automatic bit skip_byte(logic [7:0] b);
    return b == SKIP_PLUS || b == SKIP_STAR;
  endfunction

  // Does the tail of the window hold pattern p right now?
  function automatic bit pattern_in_window(int p);
    int n;
    n = kw_len[p];
    if (n == 0 || n > KLEN || n > fill) return 0;
    for (int j = 0; j < n; j++) begin
      if (skip_byte(kw_bytes[p][j])) return 0;
      if (window[KLEN-n+j] != kw_bytes[p][j]) return 0;
    end
    return 1;
  endfunction

  // Advance the predictor by one accepted item; queue a verdict on last byte.
  task automatic track_item(in_item_t it);
    int p;
    int lim;
    bit found;
    int idx;
    out_item_t v;
    p = it.keyword_index * 2 + it.variant;
    case (it.op)
      OP_LOAD_BYTE: begin
        kw_bytes[p][it.position] = it.value;
        kw_written[p][it.position] = 1;
      end
      OP_LOAD_ATTR: begin
        kw_len[p] = it.length;
        kw_pass[it.keyword_index] = it.pass_on_match;
        kw_log[it.keyword_index] = it.log_on_match;
      end
      OP_SCAN: begin
        if (!skip_byte(it.value)) begin
          for (int j = 0; j < KLEN-1; j++) window[j] = window[j+1];
          window[KLEN-1] = it.value;
          if (fill < KLEN) fill++;
          for (int q = 0; q < NPAT; q++)
            if (pattern_in_window(q)) hits[q] = 1;
        end
        if (it.last) begin
          lim = reg_count > NKW ? NKW : reg_count;
          found = 0;
          idx = 0;
          for (int k = 0; k < lim && !found; k++)
            if (hits[2*k] || hits[2*k+1]) begin
              found = 1;
              idx = k;
            end
          v.matched = found;
          v.match_index = found ? idx[KIDX_W-1:0] : '0;
          if (found && !kw_pass[idx]) begin
            v.verdict_pass = 0;
            v.action = reg_remind ? ACT_REDIRECT : ACT_TCP_RST;
          end else begin
            v.verdict_pass = 1;
            v.action = ACT_NONE;
          end
          v.log_request = found ? kw_log[idx] : 1'b0;
          v.policy = reg_policy;
          verdict_q.push_back(v);
          foreach (window[j]) window[j] = '0;
          foreach (hits[q]) hits[q] = 0;
          fill = 0;
        end
      end
      default: ;  // unused op: no effect
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Clock, receiver stalls and result checking
  // ---------------------------------------------------------------------------
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  task automatic report(string what, int got, int want);
    $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        report("unexpected verdict item", 1, 0);
      end else begin
        w = verdict_q.pop_front();
        if (out_data.matched !== w.matched) report("matched", out_data.matched, w.matched);
        if (out_data.match_index !== w.match_index)
          report("match_index", out_data.match_index, w.match_index);
        if (out_data.verdict_pass !== w.verdict_pass)
          report("verdict_pass", out_data.verdict_pass, w.verdict_pass);
        if (out_data.action !== w.action) report("action", out_data.action, w.action);
        if (out_data.log_request !== w.log_request)
          report("log_request", out_data.log_request, w.log_request);
        if (out_data.policy !== w.policy) report("policy", out_data.policy, w.policy);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving helpers
  // ---------------------------------------------------------------------------
  // Valid stays high back to back; it drops only during a sender gap or in settle().
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_item(it);
    if (it.op != OP_IGNORED) items_sent++;
  endtask

  // Drain: wait until nothing is owed, then wait out the result register.
  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_KEYWORD_COUNT: reg_count = data[4:0];
      CFG_REMIND_MODE:   reg_remind = data[0];
      CFG_POLICY_ID:     reg_policy = data;
      default: ;
    endcase
  endtask

  task automatic set_policy(logic [7:0] cnt, logic [7:0] mode, logic [7:0] pol);
    settle();
    write_reg(CFG_KEYWORD_COUNT, cnt);
    write_reg(CFG_REMIND_MODE, mode);
    write_reg(CFG_POLICY_ID, pol);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Random filler for the fields an op does not use.
  function automatic in_item_t noise_item();
    in_item_t it;
    logic [31:0] r;
    r = $urandom;
    it = in_item_t'(r[$bits(in_item_t)-1:0]);
    return it;
  endfunction

  task automatic load_byte(int k, int v, int pos, logic [7:0] b);
    in_item_t it;
    it = noise_item();
    it.op = OP_LOAD_BYTE;
    it.keyword_index = KIDX_W'(k);
    it.variant = 1'(v);
    it.position = POS_W'(pos);
    it.value = b;
    send_item(it);
  endtask

  // Load a keyword from text, topping up any unloaded byte under its length
  // so the block never compares against an unwritten byte.
  task automatic load_keyword(int k, int v, string s, int len, bit pf, bit lf);
    in_item_t it;
    int n;
    for (int j = 0; j < s.len() && j < KLEN; j++) load_byte(k, v, j, s[j]);
    n = len > KLEN ? KLEN : len;
    for (int j = 0; j < n; j++)
      if (!kw_written[k*2+v][j]) load_byte(k, v, j, 8'(8'h61 + $urandom_range(3)));
    it = noise_item();
    it.op = OP_LOAD_ATTR;
    it.keyword_index = KIDX_W'(k);
    it.variant = 1'(v);
    it.length = LEN_W'(len);
    it.pass_on_match = pf;
    it.log_on_match = lf;
    send_item(it);
  endtask

  task automatic scan_byte(logic [7:0] b, bit fin);
    in_item_t it;
    it = noise_item();
    it.op = OP_SCAN;
    it.value = b;
    it.last = fin;
    send_item(it);
  endtask

  task automatic send_request(string s);
    for (int j = 0; j < s.len(); j++) scan_byte(s[j], j == s.len()-1);
  endtask

  // Mostly a small alphabet so keywords actually hit; skip bytes and noise too.
  function automatic logic [7:0] pick_request_byte();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'(8'h61 + $urandom_range(3));
    if (r < 85) return $urandom_range(1) ? SKIP_PLUS : SKIP_STAR;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_keyword_byte();
    int r;
    r = $urandom_range(99);
    if (r < 93) return 8'(8'h61 + $urandom_range(3));
    if (r < 96) return $urandom_range(1) ? SKIP_PLUS : SKIP_STAR;
    return 8'($urandom_range(255));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // After reset no keyword is in use: every request passes untouched.
  task automatic test_reset_state();
    send_request("abcd");
    scan_byte(8'h00, 1);
  endtask

  task automatic test_directed_keywords();
    in_item_t it;
    set_policy(8'd16, 8'd1, 8'hA5);
    load_keyword(0, 0, "ab", 2, 0, 1);        // block, logged
    load_keyword(1, 1, "cd", 2, 1, 0);        // pass
    load_keyword(2, 0, "x+y", 3, 0, 1);       // holds a skip byte: never hits
    load_keyword(3, 1, "", 0, 0, 0);          // empty keyword
    load_keyword(4, 0, "", 40, 0, 1);         // longer than the window
    load_byte(15, 1, 31, 8'hFF);              // top entry, top position
    send_request("zza+b");                    // skip bytes vanish: hits 0
    send_request("c*dq");                     // hits 1 only
    send_request("xy");                       // no keyword
    send_request("x+y");
    send_request("ab+");                      // last byte is a skip byte
    it = noise_item();
    it.op = OP_IGNORED;                       // ignored op, no verdict
    send_item(it);
    send_request("cdab");                     // both hit: lowest index wins
    set_policy(8'd31, 8'd0, 8'h00);           // count saturates, TCP reset
    send_request("ab");
    load_keyword(15, 1, "", 32, 1, 1);        // full-length keyword
    set_policy(8'd0, 8'd1, 8'hFF);
    send_request("ab");
    settle();
    write_reg(CFG_UNUSED, 8'h5A);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Random table updates, requests and noise under one policy setting.
  task automatic test_random_phase(int s_idle, int r_idle, int quota);
    int goal;
    int r;
    int n;
    int len;
    string s;
    in_item_t it;
    settle();
    snd_idle = s_idle;
    rcv_idle = r_idle;
    r = $urandom_range(3);
    set_policy(r == 0 ? 8'd16 : r == 1 ? 8'($urandom_range(255)) : 8'($urandom_range(16)),
               8'($urandom_range(255)), 8'($urandom_range(255)));
    goal = items_sent + quota;
    while (items_sent < goal) begin
      r = $urandom_range(99);
      if (r < 15) begin
        n = $urandom_range(99);
        len = n < 5 ? 0 : n < 85 ? $urandom_range(1, 4) :
              n < 95 ? $urandom_range(5, 32) : $urandom_range(33, 63);
        s = "";
        for (int j = 0; j < len && j < KLEN; j++) s = {s, string'(pick_keyword_byte())};
        load_keyword($urandom_range(15), $urandom_range(1), s, len,
                     1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (r < 20) begin
        it = noise_item();
        if ($urandom_range(1)) it.op = OP_IGNORED;
        else begin
          it.op = OP_LOAD_BYTE;
          if ($urandom_range(1)) it.value = pick_keyword_byte();
        end
        send_item(it);
      end else begin
        n = $urandom_range(1, 12);
        for (int j = 0; j < n; j++) scan_byte(pick_request_byte(), j == n-1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    items_sent = 0;
    snd_idle = 15;
    rcv_idle = 56;
    fill = 0;
    reg_count = '0;
    reg_remind = 0;
    reg_policy = '0;
    foreach (kw_bytes[p, j]) begin
      kw_bytes[p][j] = '0;
      kw_written[p][j] = 0;
    end
    foreach (kw_len[p]) begin
      kw_len[p] = '0;
      hits[p] = 0;
    end
    foreach (kw_pass[k]) begin
      kw_pass[k] = 0;
      kw_log[k] = 0;
    end
    foreach (window[j]) window[j] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    test_reset_state();
    test_directed_keywords();
    test_random_phase(15, 56, 180);
    test_random_phase(56, 15, 180);
    test_random_phase(0, 0, 180);

    settle();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule
